// ===== sv/imu_median5_filter_scaler_top_assert.svh =====
// Assertion macros for the IMU median filter and scaler.
`ifndef IMU_MEDIAN5_FILTER_SCALER_TOP_ASSERT_SVH
`define IMU_MEDIAN5_FILTER_SCALER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IMF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/imf_pkg.sv =====
// Shared types and constants for the IMU median filter and scaler.
`timescale 1ns / 1ps
package imf_pkg;

    localparam int AXES       = 6;
    localparam int GYRO_AXES  = 3;
    localparam int COUNT_W    = 16;
    localparam int RATE_W     = 27;
    localparam int ACCEL_W    = 19;
    localparam int GYRO_BASE  = 250;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 144;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE   = 2'd2;

    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic [AXES-1:0][COUNT_W-1:0] sample_set_t;

    typedef struct packed {
        logic       median_enable;
        logic [1:0] gyro_range;
        logic [1:0] accel_range;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/imf_front.sv =====
// Front end: input transfer, per-axis sample rings and median selection.
`timescale 1ns / 1ps
module imf_front #(
    parameter int WINDOW = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  imf_pkg::cfg_t                        cfg,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [imf_pkg::IN_DATA_W-1:0]        s_tdata,
    input  imf_pkg::q_status_t                   q_status,
    output logic                                 q_wr,
    output imf_pkg::sample_set_t                 q_wdata,
    output logic [$clog2(WINDOW)-1:0]            slot
);
    import imf_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int MID    = WINDOW / 2;

    count_t                ring_reg [AXES][WINDOW];
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    count_t                in_count [AXES];
    count_t                win      [AXES][WINDOW];
    logic [SLOT_W-1:0]     rank     [AXES][WINDOW];
    count_t                med      [AXES];
    logic                  ring_wr;

    assign s_tready = !q_status.full;
    assign q_wr     = s_tvalid && s_tready;
    assign ring_wr  = q_wr && cfg.median_enable;
    assign slot     = slot_reg;

    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            in_count[a] = count_t'(s_tdata[a*COUNT_W +: COUNT_W]);
            for (int i = 0; i < WINDOW; i++)
            begin
                win[a][i] = (slot_reg == SLOT_W'(i)) ? in_count[a] : ring_reg[a][i];
            end
        end
    end

    // Rank each entry; equal values are ordered by position so ranks are unique.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            med[a] = '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                rank[a][i] = '0;
                for (int j = 0; j < WINDOW; j++)
                begin
                    if ((win[a][j] < win[a][i]) || ((j < i) && (win[a][j] == win[a][i])))
                    begin
                        rank[a][i] = rank[a][i] + SLOT_W'(1);
                    end
                end
                if (rank[a][i] == SLOT_W'(MID))
                begin
                    med[a] = win[a][i];
                end
            end
            q_wdata[a] = cfg.median_enable ? med[a] : in_count[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                for (int i = 0; i < WINDOW; i++)
                begin
                    ring_reg[a][i] <= '0;
                end
            end
        end
        else if (ring_wr)
        begin
            slot_reg <= slot_next;
            for (int a = 0; a < AXES; a++)
            begin
                for (int i = 0; i < WINDOW; i++)
                begin
                    if (slot_reg == SLOT_W'(i))
                    begin
                        ring_reg[a][i] <= in_count[a];
                    end
                end
            end
        end
    end

endmodule

// ===== sv/imf_queue.sv =====
// Two-entry queue of filtered sample sets between front and back.
`timescale 1ns / 1ps
module imf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  imf_pkg::sample_set_t  wdata,
    input  logic                  rd,
    output imf_pkg::sample_set_t  rdata,
    output imf_pkg::q_status_t    status
);
    import imf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sample_set_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign rdata        = entry_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/imf_back.sv =====
// Back end: fixed-point scaling and the output register.
`timescale 1ns / 1ps
module imf_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  imf_pkg::cfg_t                   cfg,
    input  imf_pkg::q_status_t              q_status,
    input  imf_pkg::sample_set_t            q_rdata,
    output logic                            q_rd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [imf_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import imf_pkg::*;

    localparam int PROD_W     = COUNT_W + 10;
    localparam int ACCEL_BASE = GYRO_AXES * RATE_W;
    localparam int USED_W     = ACCEL_BASE + (AXES - GYRO_AXES) * ACCEL_W;
    localparam logic signed [9:0] GYRO_BASE_S = 10'(GYRO_BASE);

    logic                       m_tvalid_reg;
    logic [OUT_DATA_W-1:0]      m_tdata_reg;
    logic [OUT_DATA_W-1:0]      m_tdata_next;
    logic signed [PROD_W-1:0]   prod [GYRO_AXES];

    assign q_rd     = !q_status.empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        m_tdata_next = '0;
        for (int g = 0; g < GYRO_AXES; g++)
        begin
            prod[g] = PROD_W'($signed(q_rdata[g])) * PROD_W'(GYRO_BASE_S);
            m_tdata_next[g*RATE_W +: RATE_W] = RATE_W'(prod[g]) << cfg.gyro_range;
        end
        for (int k = 0; k < AXES - GYRO_AXES; k++)
        begin
            m_tdata_next[ACCEL_BASE + k*ACCEL_W +: ACCEL_W] =
                ACCEL_W'($signed(q_rdata[GYRO_AXES + k])) << cfg.accel_range;
        end
        m_tdata_next[OUT_DATA_W-1:USED_W] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

// ===== sv/imu_median5_filter_scaler_top.sv =====
// Top level of the six-axis IMU median filter and scaler.
`timescale 1ns / 1ps
`include "imu_median5_filter_scaler_top_assert.svh"
// Takes one six-axis sample set per transfer and returns one scaled result per
// transfer, one per clock cycle sustained while m_tready stays high. With
// median filtering on, each axis count enters a WINDOW-deep ring (zero after
// reset) and the true median of the ring replaces it; a rank-compare network
// per axis picks it in the accept cycle. Gyro results are count*(250<<gyro_range)
// in 1/32768 dps, accel results count<<accel_range in 2^-14 g. A two-entry queue
// sits between the front and the output register, so a result is held in a
// queue entry and then in the output register, and the input keeps taking
// transfers while a result waits until the queue holds two sets.
// Write configuration only while the block holds no pending result.
module imu_median5_filter_scaler_top #(
    parameter int WINDOW = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [imf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // gyro_x_count, gyro_y_count, gyro_z_count, accel_x_count, accel_y_count,
    // accel_z_count, 16 bits each
    input  logic [imf_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gyro_x_rate, gyro_y_rate, gyro_z_rate (27 bits each), accel_x_value,
    // accel_y_value, accel_z_value (19 bits each), zero fill to 144 bits
    output logic [imf_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import imf_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    q_status_t          q_status;
    logic               q_wr;
    logic               q_rd;
    sample_set_t        q_wdata;
    sample_set_t        q_rdata;
    logic [SLOT_W-1:0]  slot;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MEDIAN_ENABLE: cfg_next.median_enable = cfg_data[0];
                REG_GYRO_RANGE:    cfg_next.gyro_range    = cfg_data[1:0];
                REG_ACCEL_RANGE:   cfg_next.accel_range   = cfg_data[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.median_enable <= 1'b1;
            cfg_reg.gyro_range    <= 2'd0;
            cfg_reg.accel_range   <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    imf_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata),
        .slot     (slot)
    );

    imf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wdata  (q_wdata),
        .rd     (q_rd),
        .rdata  (q_rdata),
        .status (q_status)
    );

    imf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `IMF_ASSERT_IMP(a_slot_range, 1'b1, slot <= SLOT_W'(WINDOW - 1), "ring slot out of range")
    `IMF_ASSERT_NXT(a_slot_hold, !(s_tvalid && s_tready && cfg_reg.median_enable), $stable(slot), "ring slot moved without a filtered transfer")
    `IMF_ASSERT_IMP(a_no_overflow, q_status.full, !q_wr, "queue written while full")
    `IMF_ASSERT_NXT(a_pop_loads, q_rd, m_tvalid, "queue pop did not load the output register")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the IMU median filter and scaler top level.
`timescale 1ns / 1ps
module tb;
    import imf_pkg::*;

    localparam int WINDOW      = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_BLOCKS = 17;
    localparam int BLOCK_ITEMS = 50;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Field order matches m_tdata: gyro x rate in the lowest bits, zero fill on top.
    typedef struct packed {
        logic [5:0]                fill;
        logic signed [ACCEL_W-1:0] az_value;
        logic signed [ACCEL_W-1:0] ay_value;
        logic signed [ACCEL_W-1:0] ax_value;
        logic signed [RATE_W-1:0]  gz_rate;
        logic signed [RATE_W-1:0]  gy_rate;
        logic signed [RATE_W-1:0]  gx_rate;
    } result_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        sample_set_t           set;
        bit                    typed;
        result_t               want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state: one ring per axis plus the live register settings.
    count_t     ring_hist [AXES][WINDOW];
    int         ring_slot = 0;
    bit         median_on = 1'b1;
    logic [1:0] gyro_rng  = 2'd0;
    logic [1:0] accel_rng = 2'd0;

    result_t  pending_results [$];
    dir_row_t dir_rows [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;

    imu_median5_filter_scaler_top #(
        .WINDOW(WINDOW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        foreach (ring_hist[a, s])
            ring_hist[a][s] = '0;
    end

    function automatic int ring_median(int axis);
        int v [WINDOW];
        int t;
        int j;
        for (int i = 0; i < WINDOW; i++)
        begin
            t = ring_hist[axis][i];
            j = i;
            while (j > 0 && v[j - 1] > t)
            begin
                v[j] = v[j - 1];
                j--;
            end
            v[j] = t;
        end
        return v[WINDOW / 2];
    endfunction

    function automatic result_t predict_scaled(sample_set_t set);
        longint  cnt [AXES];
        longint  gscale;
        longint  ascale;
        result_t r;
        r      = '0;
        gscale = longint'(GYRO_BASE) << gyro_rng;
        ascale = longint'(1) << accel_rng;
        for (int a = 0; a < AXES; a++)
            cnt[a] = count_t'(set[a]);
        if (median_on)
        begin
            for (int a = 0; a < AXES; a++)
                ring_hist[a][ring_slot] = set[a];
            ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
            for (int a = 0; a < AXES; a++)
                cnt[a] = ring_median(a);
        end
        r.gx_rate  = cnt[0] * gscale;
        r.gy_rate  = cnt[1] * gscale;
        r.gz_rate  = cnt[2] * gscale;
        r.ax_value = cnt[3] * ascale;
        r.ay_value = cnt[4] * ascale;
        r.az_value = cnt[5] * ascale;
        return r;
    endfunction

    function automatic sample_set_t mk_set(int gx, int gy, int gz, int ax, int ay, int az);
        sample_set_t set;
        set[0] = 16'(gx);
        set[1] = 16'(gy);
        set[2] = 16'(gz);
        set[3] = 16'(ax);
        set[4] = 16'(ay);
        set[5] = 16'(az);
        return set;
    endfunction

    function automatic sample_set_t all_axes(int v);
        return mk_set(v, v, v, v, v, v);
    endfunction

    function automatic result_t uniform_result(longint g, longint acc);
        result_t r;
        r          = '0;
        r.gx_rate  = g;
        r.gy_rate  = g;
        r.gz_rate  = g;
        r.ax_value = acc;
        r.ay_value = acc;
        r.az_value = acc;
        return r;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row      = '{kind: ROW_CFG, default: '0};
        row.idx  = idx;
        row.val  = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item(sample_set_t set, bit typed, result_t want);
        dir_row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.set   = set;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic count_t rand_count(count_t level);
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return level + count_t'($urandom_range(8)) - 16'sd4;
            default: return count_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MEDIAN_ENABLE: median_on = val[0];
            REG_GYRO_RANGE:    gyro_rng  = val;
            REG_ACCEL_RANGE:   accel_rng = val;
            default: ;
        endcase
    endtask

    // Hold the sender until every pending result has been transferred out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_sample(input sample_set_t set, input bit typed, input result_t want);
        result_t model;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= set;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model = predict_scaled(set);
        pending_results.push_back(typed ? want : model);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0)
                report_mismatch("result transfer with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                check_field("gyro_x_rate", got.gx_rate, want.gx_rate);
                check_field("gyro_y_rate", got.gy_rate, want.gy_rate);
                check_field("gyro_z_rate", got.gz_rate, want.gz_rate);
                check_field("accel_x_value", got.ax_value, want.ax_value);
                check_field("accel_y_value", got.ay_value, want.ay_value);
                check_field("accel_z_value", got.az_value, want.az_value);
                check_field("zero fill", got.fill, want.fill);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        count_t      levels [AXES];
        sample_set_t set;
        logic [1:0]  mv;
        logic [1:0]  gv;
        logic [1:0]  av;
        result_t     none;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        none      = '0;

        // Rings start at zero, so the first sets mostly see a median of zero.
        add_item(all_axes(32767), 1'b1, uniform_result(0, 0));
        add_item(all_axes(-32768), 1'b1, uniform_result(0, 0));
        add_item(all_axes(32767), 1'b1, uniform_result(0, 0));
        add_item(all_axes(32767), 1'b1, uniform_result(8191750, 32767));
        add_item(all_axes(-32768), 1'b1, uniform_result(8191750, 32767));
        add_item(mk_set(1, -1, 0, 100, -100, 32767), 1'b0, none);
        add_item(mk_set(-2, 5, 0, -100, 100, -32768), 1'b0, none);
        add_item(all_axes(5), 1'b0, none);
        add_cfg(REG_GYRO_RANGE, 2'd3);
        add_cfg(REG_ACCEL_RANGE, 2'd3);
        add_item(all_axes(-32768), 1'b0, none);
        add_item(all_axes(32767), 1'b0, none);
        add_cfg(REG_MEDIAN_ENABLE, 2'd0);
        add_item(all_axes(-32768), 1'b1, uniform_result(-65536000, -262144));
        add_item(all_axes(32767), 1'b1, uniform_result(65534000, 262136));
        add_item(all_axes(0), 1'b1, uniform_result(0, 0));
        // Only bit 0 of the enable counts: a value of two keeps filtering off.
        add_cfg(REG_MEDIAN_ENABLE, 2'd2);
        add_item(all_axes(-1), 1'b1, uniform_result(-2000, -8));
        add_cfg(REG_UNUSED, 2'd3);
        add_item(all_axes(1), 1'b1, uniform_result(2000, 8));
        add_cfg(REG_MEDIAN_ENABLE, 2'd3);
        add_item(mk_set(7, -7, 300, -300, 12, 0), 1'b0, none);
        add_item(mk_set(7, 7, 7, -300, -300, -300), 1'b0, none);
        add_cfg(REG_GYRO_RANGE, 2'd1);
        add_cfg(REG_ACCEL_RANGE, 2'd2);
        add_item(mk_set(-32768, 32767, -1, 1, 21845, -21846), 1'b0, none);
        add_item(mk_set(32767, -32768, 1, -1, -21846, 21845), 1'b0, none);
        add_item(mk_set(0, 0, 0, 0, 0, 0), 1'b0, none);
        add_cfg(REG_GYRO_RANGE, 2'd2);
        add_cfg(REG_ACCEL_RANGE, 2'd1);
        add_item(mk_set(4096, -4096, 255, -256, 16384, -16385), 1'b0, none);
        add_item(mk_set(4096, 4096, 255, 255, 16384, 16384), 1'b0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 72;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                push_sample(dir_rows[i].set, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int blk = 0; blk < RAND_BLOCKS; blk++)
        begin
            if (blk == 6)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 25;
            end
            else if (blk == 12)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            if (blk == 0)
            begin
                mv = 2'd1;
                gv = 2'd3;
                av = 2'd3;
            end
            else if (blk == 1)
            begin
                mv = 2'd1;
                gv = 2'd0;
                av = 2'd0;
            end
            else if (blk == 2)
            begin
                mv = 2'd2;
                gv = 2'($urandom_range(3));
                av = 2'($urandom_range(3));
            end
            else
            begin
                mv = {1'($urandom_range(1)), 1'($urandom_range(3) != 0)};
                gv = 2'($urandom_range(3));
                av = 2'($urandom_range(3));
            end
            write_reg(REG_MEDIAN_ENABLE, mv);
            write_reg(REG_GYRO_RANGE, gv);
            write_reg(REG_ACCEL_RANGE, av);
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, 2'($urandom_range(3)));

            // Each axis wanders around its own level so the median sees near ties.
            for (int a = 0; a < AXES; a++)
                levels[a] = count_t'($urandom);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                for (int a = 0; a < AXES; a++)
                    set[a] = rand_count(levels[a]);
                push_sample(set, 1'b0, none);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
